// ===== src/iqif_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqif_pkg
// Shared widths, CORDIC angle table and stage payload types for the
// I/Q instantaneous frequency unit.
// ----------------------------------------------------------------------------
package iqif_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int PHASE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 32;
  localparam int RATE_BITS    = 24;
  localparam int FREQ_BITS    = 24;
  // CORDIC gain is about 1.65 on a vector of length up to sqrt(2) full scale
  localparam int XY_BITS      = SAMPLE_BITS + 3;
  localparam int SHIFT_BITS   = $clog2(CORDIC_STEPS);
  localparam int PROD_BITS    = PHASE_BITS + RATE_BITS + 1;

  localparam logic [RATE_BITS-1:0]  RATE_RESET = RATE_BITS'(48000);
  localparam logic [ANGLE_BITS-1:0] HALF_TURN  = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS-1:0] PHASE_RND  =
    ANGLE_BITS'(1) << (ANGLE_BITS - 1 - PHASE_BITS);

  // atan(2^-k) in units of 2^-32 turn
  localparam logic [ANGLE_BITS-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct packed {
    logic                         valid;
    logic                         start;
    logic                         zero;
    logic signed [XY_BITS-1:0]    x;
    logic signed [XY_BITS-1:0]    y;
    logic        [ANGLE_BITS-1:0] z;
  } cdc_t;

  typedef struct packed {
    logic                 valid;
    logic [FREQ_BITS-1:0] freq;
  } res_t;

endpackage

// ===== src/iq_instantaneous_frequency_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_instantaneous_frequency_unit
// FM discriminator: CORDIC atan2 phase per I/Q item, wrapped phase step,
// scaled by the sample rate to a frequency in Hz.
//
//   channel  dir  width  contents
//   s_axis   in   32+1   tdata: sample_i, sample_q; tuser: stream_start
//   m_axis   out  24     tdata: inst_freq
//   cfg      in   24     sample_rate, reset 48000
//
// One item per cycle unless the output stalls; in order: front register, 16
// CORDIC cells, phase-step stage, multiplier stage, output register.
// The first item after reset or with stream_start set gives no result.
// A stalled output fills one skid entry; the whole pipeline holds while that
// entry is full, which is when s_axis_tready is low.
// Reset is asynchronous and clears all valid bits and the held phase.
// ----------------------------------------------------------------------------
module iq_instantaneous_frequency_unit
  import iqif_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [2*SAMPLE_BITS-1:0] s_axis_tdata,  // sample_i, sample_q
  input  logic                   s_axis_tuser,  // stream_start
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [FREQ_BITS-1:0]   m_axis_tdata,  // inst_freq
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [RATE_BITS-1:0]   cfg_data_i     // sample_rate
);

  logic                        run;
  logic [RATE_BITS-1:0]        rate_q;
  logic signed [XY_BITS-1:0]   xi, xq;
  cdc_t                        front_d, front_q;
  cdc_t                        chain [CORDIC_STEPS+1];
  res_t                        res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (cfg_valid_i) begin
      rate_q <= cfg_data_i;
    end
  end

  // left half-plane is rotated by a half turn before the micro-rotations
  always_comb begin
    xi            = XY_BITS'($signed(s_axis_tdata[SAMPLE_BITS-1:0]));
    xq            = XY_BITS'($signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
    front_d.valid = s_axis_tvalid;
    front_d.start = s_axis_tuser;
    front_d.zero  = (xi == '0) && (xq == '0);
    if (xi[XY_BITS-1]) begin
      front_d.x = -xi;
      front_d.y = -xq;
      front_d.z = HALF_TURN;
    end else begin
      front_d.x = xi;
      front_d.y = xq;
      front_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
    end else if (run) begin
      front_q <= front_d;
    end
  end

  assign chain[0] = front_q;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    iqif_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (run),
      .shift_i (SHIFT_BITS'(g)),
      .angle_i (ATAN_TURNS[g]),
      .cell_i  (chain[g]),
      .cell_o  (chain[g+1])
    );
  end

  iqif_diff_scale u_diff (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (run),
    .cell_i (chain[CORDIC_STEPS]),
    .rate_i (rate_q),
    .res_o  (res)
  );

  iqif_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (run && res.valid),
    .data_i  (res.freq),
    .run_o   (run),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  // skid entry is only used behind a held output item
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run |-> m_axis_tvalid)
    else $error("pipeline stalled with no output item");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(run) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("stall began without a blocked output");

  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run |=> $stable(front_q.valid))
    else $error("front stage moved during a stall");
`endif

endmodule

// ===== src/iqif_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqif_cordic_cell
// One vectoring CORDIC micro-rotation, registered. Drives y toward zero and
// accumulates the rotation angle.
// ----------------------------------------------------------------------------
module iqif_cordic_cell
  import iqif_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [SHIFT_BITS-1:0] shift_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  input  cdc_t                  cell_i,
  output cdc_t                  cell_o
);

  logic signed [XY_BITS-1:0] x_in, y_in, dx, dy;
  cdc_t cell_d, cell_q;

  always_comb begin
    x_in   = cell_i.x;
    y_in   = cell_i.y;
    dx     = y_in >>> shift_i;
    dy     = x_in >>> shift_i;
    cell_d = cell_i;
    if (!y_in[XY_BITS-1]) begin
      cell_d.x = x_in + dx;
      cell_d.y = y_in - dy;
      cell_d.z = cell_i.z + angle_i;
    end else begin
      cell_d.x = x_in - dx;
      cell_d.y = y_in + dy;
      cell_d.z = cell_i.z - angle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== src/iqif_diff_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqif_diff_scale
// Rounds the CORDIC angle to a phase, takes the wrapped step from the
// previous phase and scales it by the sample rate. Two register stages.
// ----------------------------------------------------------------------------
module iqif_diff_scale
  import iqif_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  cdc_t                 cell_i,
  input  logic [RATE_BITS-1:0] rate_i,
  output res_t                 res_o
);

  logic [ANGLE_BITS-1:0]        z_rnd;
  logic [PHASE_BITS-1:0]        phase;
  logic                         first;
  logic [PHASE_BITS-1:0]        prev_d, prev_q;
  logic                         have_d, have_q;
  logic                         step_vld_d, step_vld_q;
  logic signed [PHASE_BITS-1:0] step_d, step_q;
  logic                         prod_vld_q;
  logic signed [PROD_BITS-1:0]  prod_d, prod_q;

  always_comb begin
    z_rnd      = cell_i.z + PHASE_RND;
    phase      = cell_i.zero ? '0 : z_rnd[ANGLE_BITS-1 -: PHASE_BITS];
    first      = cell_i.start || !have_q;
    prev_d     = prev_q;
    have_d     = have_q;
    step_vld_d = 1'b0;
    step_d     = signed'(phase - prev_q);
    if (cell_i.valid) begin
      prev_d     = phase;
      have_d     = 1'b1;
      step_vld_d = !first;
    end
  end

  // step of exactly half a turn reads as negative by two's complement
  assign prod_d = step_q * $signed({1'b0, rate_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      have_q     <= 1'b0;
      step_vld_q <= 1'b0;
      prod_vld_q <= 1'b0;
    end else if (en_i) begin
      prev_q     <= prev_d;
      have_q     <= have_d;
      step_vld_q <= step_vld_d;
      prod_vld_q <= step_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
      prod_q <= prod_d;
    end
  end

  // floor shift right by the phase width
  assign res_o.valid = prod_vld_q;
  assign res_o.freq  = prod_q[PHASE_BITS +: FREQ_BITS];

endmodule

// ===== src/iqif_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqif_out_buf
// Output register with one skid entry. The pipeline runs while the skid
// entry is free.
// ----------------------------------------------------------------------------
module iqif_out_buf
  import iqif_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [FREQ_BITS-1:0] data_i,
  output logic                 run_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [FREQ_BITS-1:0] data_o
);

  logic                 out_vld_d, out_vld_q, skd_vld_d, skd_vld_q;
  logic [FREQ_BITS-1:0] out_d, out_q, skd_d, skd_q;
  logic                 take;

  assign take = out_vld_q && ready_i;

  always_comb begin
    out_vld_d = out_vld_q;
    skd_vld_d = skd_vld_q;
    out_d     = out_q;
    skd_d     = skd_q;
    if (skd_vld_q) begin
      if (take) begin
        out_d     = skd_q;
        skd_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q || take) begin
        out_d     = data_i;
        out_vld_d = 1'b1;
      end else begin
        skd_d     = data_i;
        skd_vld_d = 1'b1;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      skd_vld_q <= skd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skd_q <= skd_d;
  end

  assign run_o   = !skd_vld_q;
  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule
